// ----- rtl/bbpe_pkg.sv -----
package bbpe_pkg;

   // Coordinate and parameter formats
   localparam int COORD_WIDTH = 32;
   localparam int VTX_W       = 32;
   localparam int IDX_W       = 4;
   localparam int PARAM_W     = 17;
   localparam int QS_W        = 31;
   localparam int WGT_W       = 17;
   localparam int FRAC_W      = 16;

   // Shared multiplier: signed A holds a coordinate or a zero-extended weight
   localparam int MB_W   = WGT_W + 1;
   localparam int MA_W   = (COORD_WIDTH > MB_W) ? COORD_WIDTH : MB_W;
   localparam int PROD_W = MA_W + MB_W;
   localparam int ACC_W  = COORD_WIDTH + 3;
   localparam int WIDE_W = COORD_WIDTH + 35;

   localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(1 << FRAC_W);

   // Sequencer lengths
   localparam int WGT_STEPS   = 12;
   localparam int BLEND_SLOTS = 20;
   localparam int NUM_AXES    = 3;
   localparam int NUM_CORNERS = 4;

   // Item operation codes
   localparam logic OPER_LOAD = 1'b0;
   localparam logic OPER_EVAL = 1'b1;

   // Datapath step codes
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_SQR  = 3'd1;
   localparam logic [2:0] OP_WGT  = 3'd2;
   localparam logic [2:0] OP_ROW  = 3'd3;
   localparam logic [2:0] OP_COL  = 3'd4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [ACC_W-1:0]       acc_type;
   typedef logic signed [WIDE_W-1:0]      wide_type;
   typedef logic signed [MA_W-1:0]        mula_type;
   typedef logic signed [MB_W-1:0]        mulb_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic [WGT_W-1:0]              wgt_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                     operation;
      logic [IDX_W-1:0]         point_index;
      logic signed [VTX_W-1:0]  point_x;
      logic signed [VTX_W-1:0]  point_y;
      logic signed [VTX_W-1:0]  point_z;
      logic [PARAM_W-1:0]       param_u;
      logic [PARAM_W-1:0]       param_v;
   } req_type;

   typedef struct packed {
      logic signed [VTX_W-1:0] vertex_x;
      logic signed [VTX_W-1:0] vertex_y;
      logic signed [VTX_W-1:0] vertex_z;
      logic                    corner_last;
   } rsp_type;

   // One multiplier step; travels on into the writeback stage
   typedef struct packed {
      logic [2:0] op;
      logic       sel_v;
      logic [1:0] axis;
      logic [1:0] row;
      logic [1:0] col;
      logic       first;
      logic       last;
   } step_type;

   typedef struct packed {
      logic       load;
      logic       capture;
      step_type   step;
      logic       finish;
      logic       emit_load;
      logic [1:0] corner;
   } cmd_type;

   // Saturate a wide signed value to the coordinate range
   function automatic coord_type sat_wide(input wide_type v);
      logic [WIDE_W-COORD_WIDTH:0] top;
      coord_type                   r;
      top = v[WIDE_W-1:COORD_WIDTH-1];
      if ((&top) || (~|top)) begin
         r = coord_type'(v);
      end else if (v[WIDE_W-1]) begin
         r = COORD_MIN;
      end else begin
         r = COORD_MAX;
      end
      return r;
   endfunction

   // Limit a parameter to one
   function automatic wgt_type clamp_param(input logic [PARAM_W-1:0] p);
      wgt_type r;
      r = (p > ONE_Q16) ? ONE_Q16 : WGT_W'(p);
      return r;
   endfunction

endpackage

// ----- rtl/bbpe_ctrl.sv -----
module bbpe_ctrl import bbpe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_operation,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WGT    = 3'd1;
   localparam logic [2:0] ST_BLEND  = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] corner_ff, corner_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] wj;
   step_type   wgt_step, blend_step;

   // Weight schedule: squares of s and t for u then v, then the four weights of u, of v
   always_comb begin
      wgt_step = '0;
      wj = 3'(cnt_ff - 5'd4);
      if (cnt_ff < 5'd4) begin
         wgt_step.op    = OP_SQR;
         wgt_step.sel_v = cnt_ff[1];
         wgt_step.col   = {1'b0, cnt_ff[0]};
      end else begin
         wgt_step.op    = OP_WGT;
         wgt_step.sel_v = wj[2];
         wgt_step.col   = wj[1:0];
      end
   end

   // Blend schedule per axis: rows 0 and 1, then each row's v blend slotted
   // in behind the next row so the row result is always settled
   always_comb begin
      blend_step      = '0;
      blend_step.axis = axis_ff;
      case (cnt_ff) inside
         [5'd0:5'd3]: begin
            blend_step.op  = OP_ROW;
            blend_step.row = 2'd0;
            blend_step.col = cnt_ff[1:0];
         end
         [5'd4:5'd7]: begin
            blend_step.op  = OP_ROW;
            blend_step.row = 2'd1;
            blend_step.col = cnt_ff[1:0];
         end
         5'd8: begin
            blend_step.op  = OP_COL;
            blend_step.row = 2'd0;
         end
         [5'd9:5'd12]: begin
            blend_step.op  = OP_ROW;
            blend_step.row = 2'd2;
            blend_step.col = 2'(cnt_ff - 5'd9);
         end
         5'd13: begin
            blend_step.op  = OP_COL;
            blend_step.row = 2'd1;
         end
         [5'd14:5'd17]: begin
            blend_step.op  = OP_ROW;
            blend_step.row = 2'd3;
            blend_step.col = 2'(cnt_ff - 5'd14);
         end
         5'd18: begin
            blend_step.op  = OP_COL;
            blend_step.row = 2'd2;
         end
         5'd19: begin
            blend_step.op  = OP_COL;
            blend_step.row = 2'd3;
         end
         default: begin
            blend_step.op = OP_NONE;
         end
      endcase
      if (blend_step.op == OP_ROW) begin
         blend_step.first = (blend_step.col == 2'd0);
         blend_step.last  = (blend_step.col == 2'd3);
      end else if (blend_step.op == OP_COL) begin
         blend_step.first = (blend_step.row == 2'd0);
         blend_step.last  = (blend_step.row == 2'd3);
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      corner_in    = corner_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OPER_EVAL) begin
                  cmd.capture = 1'b1;
                  cnt_in      = '0;
                  state_in    = ST_WGT;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_WGT: begin
            cmd.step = wgt_step;
            if (cnt_ff == 5'(WGT_STEPS - 1)) begin
               cnt_in   = '0;
               axis_in  = '0;
               state_in = ST_BLEND;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_BLEND: begin
            cmd.step = blend_step;
            if (cnt_ff == 5'(BLEND_SLOTS - 1)) begin
               cnt_in = '0;
               if (axis_ff == 2'(NUM_AXES - 1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish    = 1'b1;
            cmd.emit_load = 1'b1;
            cmd.corner    = '0;
            corner_in     = '0;
            rsp_valid_in  = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_valid_ff && !rsp_stall) begin
               if (corner_ff == 2'(NUM_CORNERS - 1)) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  corner_in     = corner_ff + 2'd1;
                  cmd.emit_load = 1'b1;
                  cmd.corner    = corner_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= '0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/bbpe_datapath.sv -----
module bbpe_datapath import bbpe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  req_type         req_data,
   input  logic            csr_wr_en,
   input  logic [QS_W-1:0] csr_wr_data,
   output rsp_type         rsp_data
);

   coord_type       grid_x_ff [16];
   coord_type       grid_y_ff [16];
   coord_type       grid_z_ff [16];
   logic [QS_W-1:0] quad_size_ff;
   step_type        s2_ff;

   wgt_type   t_ff  [2];
   wgt_type   ss_ff [2];
   wgt_type   tt_ff [2];
   wgt_type   w_ff  [8];
   prod_type  mul_ff;
   acc_type   racc_ff, oacc_ff;
   coord_type row_ff;
   coord_type px_ff, py_ff, pz_ff;
   coord_type pxd_ff, pzd_ff;
   rsp_type   rsp_ff;

   wgt_type    t_sel, s_sel, ss_sel, tt_sel, w_rd_data;
   logic [2:0] w_rd;
   logic [3:0] g_idx;
   coord_type  g_rd;
   mula_type   mul_a;
   mulb_type   mul_b;
   acc_type    sh, racc_sum, oacc_sum;
   wgt_type    sh_w, sh_w3;
   coord_type  cx, cz;

   // Select multiplier operands for the issuing step
   always_comb begin
      t_sel     = t_ff[cmd.step.sel_v];
      s_sel     = ONE_Q16 - t_sel;
      ss_sel    = ss_ff[cmd.step.sel_v];
      tt_sel    = tt_ff[cmd.step.sel_v];
      w_rd      = (cmd.step.op == OP_COL) ? {1'b1, cmd.step.row} : {1'b0, cmd.step.col};
      w_rd_data = w_ff[w_rd];
      g_idx     = {cmd.step.row, cmd.step.col};
      case (cmd.step.axis)
         2'd0:    g_rd = grid_x_ff[g_idx];
         2'd1:    g_rd = grid_y_ff[g_idx];
         default: g_rd = grid_z_ff[g_idx];
      endcase
      case (cmd.step.op)
         OP_SQR: begin
            mul_a = cmd.step.col[0] ? mula_type'({1'b0, t_sel}) : mula_type'({1'b0, s_sel});
            mul_b = cmd.step.col[0] ? mulb_type'({1'b0, t_sel}) : mulb_type'({1'b0, s_sel});
         end
         OP_WGT: begin
            mul_a = cmd.step.col[1] ? mula_type'({1'b0, tt_sel}) : mula_type'({1'b0, ss_sel});
            mul_b = cmd.step.col[0] ? mulb_type'({1'b0, t_sel}) : mulb_type'({1'b0, s_sel});
         end
         OP_ROW: begin
            mul_a = mula_type'(g_rd);
            mul_b = mulb_type'({1'b0, w_rd_data});
         end
         OP_COL: begin
            mul_a = mula_type'(row_ff);
            mul_b = mulb_type'({1'b0, w_rd_data});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Writeback values: floor shift of the product, sums before saturation
   always_comb begin
      sh       = acc_type'(mul_ff >>> FRAC_W);
      sh_w     = sh[WGT_W-1:0];
      sh_w3    = sh_w + {sh_w[WGT_W-2:0], 1'b0};
      racc_sum = (s2_ff.first ? acc_type'(0) : racc_ff) + sh;
      oacc_sum = (s2_ff.first ? acc_type'(0) : oacc_ff) + sh;
   end

   // Pick the fields of the corner being loaded
   always_comb begin
      cx = ((cmd.corner == 2'd1) || (cmd.corner == 2'd2)) ? pxd_ff : px_ff;
      cz = ((cmd.corner == 2'd2) || (cmd.corner == 2'd3)) ? pzd_ff : pz_ff;
   end

   // Held state: grid, size register, writeback stage step
   always_ff @(posedge clock) begin
      if (reset) begin
         quad_size_ff <= '0;
         s2_ff        <= '0;
         for (int k = 0; k < 16; k++) begin
            grid_x_ff[k] <= '0;
            grid_y_ff[k] <= '0;
            grid_z_ff[k] <= '0;
         end
      end else begin
         s2_ff <= cmd.step;
         if (csr_wr_en) begin
            quad_size_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            grid_x_ff[req_data.point_index] <= sat_wide(wide_type'(req_data.point_x));
            grid_y_ff[req_data.point_index] <= sat_wide(wide_type'(req_data.point_y));
            grid_z_ff[req_data.point_index] <= sat_wide(wide_type'(req_data.point_z));
         end
      end
   end

   // Working registers: multiplier, weights, accumulators, corners
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (cmd.capture) begin
         t_ff[0] <= clamp_param(req_data.param_u);
         t_ff[1] <= clamp_param(req_data.param_v);
      end
      case (s2_ff.op)
         OP_SQR: begin
            if (s2_ff.col[0]) begin
               tt_ff[s2_ff.sel_v] <= sh_w;
            end else begin
               ss_ff[s2_ff.sel_v] <= sh_w;
            end
         end
         OP_WGT: begin
            if ((s2_ff.col == 2'd1) || (s2_ff.col == 2'd2)) begin
               w_ff[{s2_ff.sel_v, s2_ff.col}] <= sh_w3;
            end else begin
               w_ff[{s2_ff.sel_v, s2_ff.col}] <= sh_w;
            end
         end
         OP_ROW: begin
            racc_ff <= racc_sum;
            if (s2_ff.last) begin
               row_ff <= sat_wide(wide_type'(racc_sum));
            end
         end
         OP_COL: begin
            oacc_ff <= oacc_sum;
            if (s2_ff.last) begin
               case (s2_ff.axis)
                  2'd0:    px_ff <= sat_wide(wide_type'(oacc_sum));
                  2'd1:    py_ff <= sat_wide(wide_type'(oacc_sum));
                  default: pz_ff <= sat_wide(wide_type'(oacc_sum));
               endcase
            end
         end
         default: begin
         end
      endcase
      if (cmd.finish) begin
         pxd_ff <= sat_wide(wide_type'(px_ff) + wide_type'(quad_size_ff));
         pzd_ff <= sat_wide(wide_type'(pz_ff) + wide_type'(quad_size_ff));
      end
      if (cmd.emit_load) begin
         rsp_ff.vertex_x    <= VTX_W'(cx);
         rsp_ff.vertex_y    <= VTX_W'(py_ff);
         rsp_ff.vertex_z    <= VTX_W'(cz);
         rsp_ff.corner_last <= (cmd.corner == 2'(NUM_CORNERS - 1));
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/bicubic_bezier_patch_eval_top.sv -----
// Load beat: one per cycle while the sequencer is idle, written into the control grid at the edge it is taken.
// Evaluate beat: the weight steps, blend steps, drain and finish run first, then four corners follow.
// Evaluates do not overlap: the one shared multiplier issues 72 products
// (12 for the weights, 60 for the blends), then come drain, finish, four corner beats (each
// can be held by rsp_stall) and the idle state that takes the next beat; no beat is taken before.
// Synchronous active-high reset clears the grid to zero, quad_size to zero, the sequencer to idle.
module bicubic_bezier_patch_eval_top import bbpe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data,
   input  logic            csr_wr_en,
   input  logic [QS_W-1:0] csr_wr_data
);

   cmd_type cmd;

   bbpe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd)
   );

   bbpe_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

   // Hold the input side while corners are pending
   a_stall_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while corners pending");

   // Evaluate beat starts the sequencer
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.operation == OPER_EVAL)) |=> req_stall)
      else $error("evaluate beat did not start the sequencer");

   // Load beat produces no corner
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.operation == OPER_LOAD)) |=> !rsp_valid)
      else $error("load beat raised a result");

   // Last corner ends the burst
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.corner_last) |=> (!rsp_valid && !req_stall))
      else $error("burst continued after last corner");

endmodule
